>>> hw/rtl/sphere_grid_vertex_generator_macros.svh
// ----------------------------------------------------------------------------
// Sphere grid vertex generator assertion macros
// Concurrent assertion wrappers on clk and rst_n; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef SPHERE_GRID_VERTEX_GENERATOR_MACROS_SVH
`define SPHERE_GRID_VERTEX_GENERATOR_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication
`define SGVG_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sgvg: assertion failed");
// Next-cycle implication
`define SGVG_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sgvg: assertion failed");
`else
`define SGVG_ASSERT_IMP(lbl, ante, cons)
`define SGVG_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

>>> hw/rtl/sgvg_pkg.sv
// ----------------------------------------------------------------------------
// Sphere grid vertex generator package
// Shared widths, fixed-point constants, sine tables and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package sgvg_pkg;

    // Angle phase, 2^32 is one full turn
    localparam int ANGLE_W = 32;
    // Magnitude of a Q1.30 value in [0, 1]
    localparam int MAG_W = 31;
    localparam int POS_MAG_W = 16;
    localparam int NORM_MAG_W = 15;
    localparam int TEX_W = 17;
    localparam int RADIUS_W = 16;

    localparam logic [30:0] Q30_ONE = 31'h4000_0000;
    localparam logic [61:0] ROUND_Q30 = 62'h0000_0000_2000_0000;
    localparam logic [31:0] ROUND_Q16 = 32'h0000_8000;
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
    localparam logic [1:0] QUARTER_TURN = 2'd1;

    // Horner divisors and floor(2^32 / d) reciprocals
    localparam int HORNER_STEPS = 5;
    localparam logic [7:0] HORNER_DIV [0:HORNER_STEPS-1] = '{
        8'd110, 8'd72, 8'd42, 8'd20, 8'd6
    };
    localparam logic [31:0] HORNER_RECIP [0:HORNER_STEPS-1] = '{
        32'd39045157, 32'd59652323, 32'd102261126, 32'd214748364, 32'd715827882
    };

    // Sine unit: fold, angle scale, square, three per Horner step, product, clamp
    localparam int SIN_LATENCY = 3 + 3 * HORNER_STEPS + 2;

    // Configuration port
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEGMENTS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RINGS = 2'd2;

    // Signed sine result as magnitude and sign
    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
    } sin_val_t;

endpackage

`default_nettype wire

>>> hw/rtl/sgvg_sin.sv
// ----------------------------------------------------------------------------
// Sphere grid vertex generator sine unit
// Pipelined sine of a 32-bit turn phase: quadrant fold, odd polynomial
// by Horner steps with reciprocal division, clamp. One phase per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sgvg_sin
(
    input  wire logic                           clk,
    input  wire logic [sgvg_pkg::ANGLE_W-1:0]   phase,
    output sgvg_pkg::sin_val_t                  result
);

    localparam int HN = sgvg_pkg::HORNER_STEPS;
    localparam int MW = sgvg_pkg::MAG_W;
    // Stage positions of the delayed operands
    localparam int R2_FIRST = 3;
    localparam int R2_LAST = R2_FIRST + 3 * (HN - 1);
    localparam int R_LAST = R2_FIRST + 3 * HN;
    localparam int NEG_LAST = R_LAST + 1;

    logic [MW-1:0] g_reg;
    logic [MW-1:0] g_next;
    logic [MW-1:0] r_pipe [2:R_LAST];
    logic [MW-1:0] r_next;
    logic [31:0]   r2_pipe [R2_FIRST:R2_LAST];
    logic [31:0]   r2_next;
    logic          neg_pipe [1:NEG_LAST];
    logic [31:0]   hv_reg [0:HN-1];
    logic [31:0]   hv_next [0:HN-1];
    logic [31:0]   hq_reg [0:HN-1];
    logic [31:0]   hq_next [0:HN-1];
    logic [31:0]   hv2_reg [0:HN-1];
    logic [MW-1:0] t_reg [0:HN-1];
    logic [MW-1:0] t_next [0:HN-1];
    logic [31:0]   s_reg;
    logic [31:0]   s_next;
    logic [MW-1:0] mag_reg;
    logic [MW-1:0] mag_next;
    logic          neg_reg;

    // Fold the quadrant onto the first quarter turn
    always_comb
    begin
        if (phase[30])
        begin
            g_next = sgvg_pkg::Q30_ONE - {1'b0, phase[29:0]};
        end
        else
        begin
            g_next = {1'b0, phase[29:0]};
        end
    end

    // Scale to radians and square
    always_comb
    begin
        logic [61:0] rp;
        logic [61:0] sq;
        rp = 62'(g_reg) * 62'(sgvg_pkg::HALF_PI_Q30) + sgvg_pkg::ROUND_Q30;
        r_next = rp[60:30];
        sq = 62'(r_pipe[2]) * 62'(r_pipe[2]) + sgvg_pkg::ROUND_Q30;
        r2_next = sq[61:30];
    end

    // Horner steps: product, reciprocal estimate, correct and subtract
    always_comb
    begin
        logic [62:0] vp;
        logic [63:0] qp;
        logic [31:0] qd;
        logic [31:0] rem;
        logic [31:0] qfix;
        logic [MW-1:0] t_in;
        for (int i = 0; i < HN; i++)
        begin
            t_in = (i == 0) ? sgvg_pkg::Q30_ONE : t_reg[(i == 0) ? 0 : i - 1];
            vp = 63'(r2_pipe[R2_FIRST + 3 * i]) * 63'(t_in)
                + 63'(sgvg_pkg::ROUND_Q30);
            hv_next[i] = vp[61:30];
            qp = 64'(hv_reg[i]) * 64'(sgvg_pkg::HORNER_RECIP[i]);
            hq_next[i] = qp[63:32];
            qd = hq_reg[i] * 32'(sgvg_pkg::HORNER_DIV[i]);
            rem = hv2_reg[i] - qd;
            qfix = hq_reg[i] + 32'(rem >= 32'(sgvg_pkg::HORNER_DIV[i]));
            t_next[i] = sgvg_pkg::Q30_ONE - qfix[MW-1:0];
        end
    end

    // Final product and clamp to one
    always_comb
    begin
        logic [61:0] sp;
        sp = 62'(r_pipe[R_LAST]) * 62'(t_reg[HN-1]) + sgvg_pkg::ROUND_Q30;
        s_next = sp[61:30];
        if (s_reg > 32'(sgvg_pkg::Q30_ONE))
        begin
            mag_next = sgvg_pkg::Q30_ONE;
        end
        else
        begin
            mag_next = s_reg[MW-1:0];
        end
    end

    // Advance the pipeline
    always_ff @(posedge clk)
    begin
        g_reg <= g_next;
        neg_pipe[1] <= phase[31];
        for (int k = 2; k <= NEG_LAST; k++)
        begin
            neg_pipe[k] <= neg_pipe[k-1];
        end
        r_pipe[2] <= r_next;
        for (int k = 3; k <= R_LAST; k++)
        begin
            r_pipe[k] <= r_pipe[k-1];
        end
        r2_pipe[R2_FIRST] <= r2_next;
        for (int k = R2_FIRST + 1; k <= R2_LAST; k++)
        begin
            r2_pipe[k] <= r2_pipe[k-1];
        end
        for (int i = 0; i < HN; i++)
        begin
            hv_reg[i] <= hv_next[i];
            hq_reg[i] <= hq_next[i];
            hv2_reg[i] <= hv_reg[i];
            t_reg[i] <= t_next[i];
        end
        s_reg <= s_next;
        mag_reg <= mag_next;
        neg_reg <= neg_pipe[NEG_LAST];
    end

    assign result = {neg_reg, mag_reg};

endmodule

`default_nettype wire

>>> hw/rtl/sphere_grid_vertex_generator.sv
// ----------------------------------------------------------------------------
// Sphere grid vertex generator
// Turns a (ring, segment) grid point of a UV sphere into position, inward
// normal, texture coordinate and quad base indices.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a transaction is taken at each rising edge with start
//   high and busy low. busy never rises, so a grid point may enter every cycle.
//   Results: done is high for one cycle with all result ports valid; the
//   receiver takes them then and cannot hold them off.
//   Throughput: one vertex per cycle. Pipeline: the 9-stage ring/segment long
//   divider (one leading quotient bit, then 4 a stage) and the 20-stage sine
//   units.
//   Configuration: cfg_valid/cfg_ready write channel, always ready; write only
//   when no transaction is in flight. Indexes: 0 radius, 1 segments, 2 rings.
//   Reset: rst_n clears the in-flight valid bits and loads radius 1.0,
//   32 segments and 16 rings. Grid points beyond the counts report
//   out_of_grid with all other fields zero.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sphere_grid_vertex_generator_macros.svh"

module sphere_grid_vertex_generator
#(
    parameter int GRID_BITS = 10
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // command channel
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [GRID_BITS-1:0]              ring_index,
    input  wire logic [GRID_BITS-1:0]              segment_index,
    // configuration channel
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [sgvg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [sgvg_pkg::CFG_DATA_W-1:0]   cfg_data,
    // result channel
    output logic                                   done,
    output logic signed [16:0]                     pos_x,
    output logic signed [16:0]                     pos_y,
    output logic signed [16:0]                     pos_z,
    output logic signed [15:0]                     norm_x,
    output logic signed [15:0]                     norm_y,
    output logic signed [15:0]                     norm_z,
    output logic [sgvg_pkg::TEX_W-1:0]             tex_u,
    output logic [sgvg_pkg::TEX_W-1:0]             tex_v,
    output logic                                   quad_valid,
    output logic [2*GRID_BITS-1:0]                 base_current,
    output logic [2*GRID_BITS-1:0]                 base_next,
    output logic                                   out_of_grid
);

    localparam int G = GRID_BITS;
    localparam int BW = 2 * GRID_BITS;
    localparam int QW = sgvg_pkg::ANGLE_W + 1;
    localparam int DIV_STEPS = 4;
    localparam int DIV_STAGES = sgvg_pkg::ANGLE_W / DIV_STEPS;
    localparam int TEX_POS = 16 / DIV_STEPS;
    localparam int POS_PHASE = DIV_STAGES + 1;
    localparam int POS_SIN = POS_PHASE + sgvg_pkg::SIN_LATENCY;
    localparam int POS_PROD = POS_SIN + 1;
    localparam int POS_SCALE = POS_PROD + 1;
    localparam int POS_OUT = POS_SCALE + 1;
    localparam int MW = sgvg_pkg::MAG_W;

    typedef struct packed {
        logic          oog;
        logic          qv;
        logic [BW-1:0] cur;
        logic [BW-1:0] nxt;
    } meta_t;

    typedef struct packed {
        logic [sgvg_pkg::TEX_W-1:0] u;
        logic [sgvg_pkg::TEX_W-1:0] v;
    } tex_t;

    logic [15:0]  radius_reg;
    logic [G-1:0] seg_cnt_reg;
    logic [G-1:0] ring_cnt_reg;
    logic [G-1:0] rings;
    logic [G-1:0] segs;
    logic [G-1:0] div_d [0:1];
    logic [G-1:0] div_x [0:1];
    logic         accept;
    logic         vld_reg [0:POS_OUT];

    logic [QW-1:0] dq_reg [0:1][0:DIV_STAGES];
    logic [QW-1:0] dq_next [0:1][0:DIV_STAGES];
    logic [G-1:0]  dr_reg [0:1][0:DIV_STAGES];
    logic [G-1:0]  dr_next [0:1][0:DIV_STAGES];

    logic [G-1:0] ring0_reg;
    logic [G-1:0] seg0_reg;
    logic         oog0_reg;
    logic         qv0_reg;
    meta_t        meta_pipe [1:POS_OUT-1];
    meta_t        meta1_next;
    meta_t        meta2_next;
    tex_t         tex_pipe [TEX_POS+1:POS_OUT-1];
    tex_t         tex_next;

    logic [sgvg_pkg::ANGLE_W-1:0] phase_reg [0:3];
    logic [sgvg_pkg::ANGLE_W-1:0] phi_next;
    logic [sgvg_pkg::ANGLE_W-1:0] theta_next;
    sgvg_pkg::sin_val_t           sin_val [0:3];

    logic [MW-1:0]                 u_mag_reg [0:2];
    logic [MW-1:0]                 u_mag_next [0:2];
    logic                          u_neg_reg [0:2];
    logic [sgvg_pkg::POS_MAG_W-1:0]  pm_reg [0:2];
    logic [sgvg_pkg::POS_MAG_W-1:0]  pm_next [0:2];
    logic [sgvg_pkg::NORM_MAG_W-1:0] nm_reg [0:2];
    logic [sgvg_pkg::NORM_MAG_W-1:0] nm_next [0:2];
    logic                          s_neg_reg [0:2];

    logic signed [16:0] pos_reg [0:2];
    logic signed [15:0] norm_reg [0:2];
    logic [sgvg_pkg::TEX_W-1:0] tex_u_reg;
    logic [sgvg_pkg::TEX_W-1:0] tex_v_reg;
    logic          qv_reg;
    logic [BW-1:0] cur_reg;
    logic [BW-1:0] nxt_reg;
    logic          oog_reg;
    logic          oog_fields_zero;

    // Pipeline takes a transaction every cycle; configuration is always taken
    assign busy = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept = start && !busy;

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= 16'd256;
            seg_cnt_reg <= G'(32);
            ring_cnt_reg <= G'(16);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                sgvg_pkg::CFG_RADIUS:   radius_reg <= cfg_data[15:0];
                sgvg_pkg::CFG_SEGMENTS: seg_cnt_reg <= cfg_data[G-1:0];
                sgvg_pkg::CFG_RINGS:    ring_cnt_reg <= cfg_data[G-1:0];
                default:                ;
            endcase
        end
    end

    // A zero count acts as one
    assign rings = (ring_cnt_reg == '0) ? G'(1) : ring_cnt_reg;
    assign segs = (seg_cnt_reg == '0) ? G'(1) : seg_cnt_reg;
    assign div_d[0] = rings;
    assign div_d[1] = segs;
    assign div_x[0] = ring_index;
    assign div_x[1] = segment_index;

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= POS_OUT; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else
        begin
            vld_reg[0] <= accept;
            for (int k = 1; k <= POS_OUT; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // Long division of index * 2^32 by the count: one leading quotient bit, then four a stage
    always_comb
    begin
        logic [QW-1:0] qv;
        logic [G-1:0]  rv;
        logic [G:0]    trial;
        for (int l = 0; l < 2; l++)
        begin
            if (div_x[l] >= div_d[l])
            begin
                dq_next[l][0] = QW'(1);
                dr_next[l][0] = div_x[l] - div_d[l];
            end
            else
            begin
                dq_next[l][0] = '0;
                dr_next[l][0] = div_x[l];
            end
            for (int k = 1; k <= DIV_STAGES; k++)
            begin
                qv = dq_reg[l][k-1];
                rv = dr_reg[l][k-1];
                for (int s = 0; s < DIV_STEPS; s++)
                begin
                    trial = {rv, 1'b0};
                    if (trial >= {1'b0, div_d[l]})
                    begin
                        trial = trial - {1'b0, div_d[l]};
                        qv = {qv[QW-2:0], 1'b1};
                    end
                    else
                    begin
                        qv = {qv[QW-2:0], 1'b0};
                    end
                    rv = trial[G-1:0];
                end
                dq_next[l][k] = qv;
                dr_next[l][k] = rv;
            end
        end
    end

    // Round the texture quotients at 2^16
    always_comb
    begin
        logic [G:0] sum_u;
        logic [G:0] sum_v;
        sum_u = {1'b0, dr_reg[1][TEX_POS]} + {1'b0, segs >> 1};
        sum_v = {1'b0, dr_reg[0][TEX_POS]} + {1'b0, rings >> 1};
        tex_next.u = dq_reg[1][TEX_POS][sgvg_pkg::TEX_W-1:0]
            + sgvg_pkg::TEX_W'(sum_u >= {1'b0, segs});
        tex_next.v = dq_reg[0][TEX_POS][sgvg_pkg::TEX_W-1:0]
            + sgvg_pkg::TEX_W'(sum_v >= {1'b0, rings});
    end

    // Round the phases; phi drops one quotient bit to get ring * 2^31 / rings
    always_comb
    begin
        logic [G:0] rem31;
        logic [G:0] sum_p;
        logic [G:0] sum_t;
        rem31 = {1'b0, dr_reg[0][DIV_STAGES]}
            + (dq_reg[0][DIV_STAGES][0] ? {1'b0, rings} : '0);
        sum_p = {1'b0, rem31[G:1]} + {1'b0, rings >> 1};
        phi_next = dq_reg[0][DIV_STAGES][QW-1:1]
            + sgvg_pkg::ANGLE_W'(sum_p >= {1'b0, rings});
        sum_t = {1'b0, dr_reg[1][DIV_STAGES]} + {1'b0, segs >> 1};
        theta_next = dq_reg[1][DIV_STAGES][sgvg_pkg::ANGLE_W-1:0]
            + sgvg_pkg::ANGLE_W'(sum_t >= {1'b0, segs});
    end

    // Base index of the quad
    always_comb
    begin
        logic [BW:0] prod;
        prod = (BW+1)'(ring0_reg) * (BW+1)'({1'b0, segs} + 1'b1) + (BW+1)'(seg0_reg);
        meta1_next.oog = oog0_reg;
        meta1_next.qv = qv0_reg;
        meta1_next.cur = prod[BW-1:0];
        meta1_next.nxt = '0;
    end

    // Base index on the next ring
    always_comb
    begin
        meta2_next = meta_pipe[1];
        meta2_next.nxt = meta_pipe[1].cur + BW'({1'b0, segs} + 1'b1);
    end

    // Advance divider and side data
    always_ff @(posedge clk)
    begin
        for (int l = 0; l < 2; l++)
        begin
            for (int k = 0; k <= DIV_STAGES; k++)
            begin
                dq_reg[l][k] <= dq_next[l][k];
                dr_reg[l][k] <= dr_next[l][k];
            end
        end
        ring0_reg <= ring_index;
        seg0_reg <= segment_index;
        oog0_reg <= (ring_index > rings) || (segment_index > segs);
        qv0_reg <= (ring_index < rings) && (segment_index < segs);
        meta_pipe[1] <= meta1_next;
        meta_pipe[2] <= meta2_next;
        for (int k = 3; k < POS_OUT; k++)
        begin
            meta_pipe[k] <= meta_pipe[k-1];
        end
        tex_pipe[TEX_POS+1] <= tex_next;
        for (int k = TEX_POS + 2; k < POS_OUT; k++)
        begin
            tex_pipe[k] <= tex_pipe[k-1];
        end
        // sin phi, cos phi, sin theta, cos theta
        phase_reg[0] <= phi_next;
        phase_reg[1] <= {phi_next[31:30] + sgvg_pkg::QUARTER_TURN, phi_next[29:0]};
        phase_reg[2] <= theta_next;
        phase_reg[3] <= {theta_next[31:30] + sgvg_pkg::QUARTER_TURN, theta_next[29:0]};
    end

    // Four sine units
    for (genvar j = 0; j < 4; j++)
    begin : g_sin
        sgvg_sin u_sin
        (
            .clk    (clk),
            .phase  (phase_reg[j]),
            .result (sin_val[j])
        );
    end

    // Unit direction: sin phi times cos and sin theta, cos phi direct
    always_comb
    begin
        logic [61:0] px;
        logic [61:0] pz;
        px = 62'(sin_val[0].mag) * 62'(sin_val[3].mag) + sgvg_pkg::ROUND_Q30;
        pz = 62'(sin_val[0].mag) * 62'(sin_val[2].mag) + sgvg_pkg::ROUND_Q30;
        u_mag_next[0] = px[60:30];
        u_mag_next[1] = sin_val[1].mag;
        u_mag_next[2] = pz[60:30];
    end

    // Scale by radius and round the normal
    always_comb
    begin
        logic [46:0] sp;
        logic [31:0] np;
        for (int j = 0; j < 3; j++)
        begin
            sp = 47'(u_mag_reg[j]) * 47'(radius_reg) + 47'(sgvg_pkg::ROUND_Q30);
            pm_next[j] = sp[45:30];
            np = 32'(u_mag_reg[j]) + sgvg_pkg::ROUND_Q16;
            nm_next[j] = np[30:16];
        end
    end

    // Product, scale and output stages
    always_ff @(posedge clk)
    begin
        u_mag_reg[0] <= u_mag_next[0];
        u_mag_reg[1] <= u_mag_next[1];
        u_mag_reg[2] <= u_mag_next[2];
        u_neg_reg[0] <= sin_val[0].neg ^ sin_val[3].neg;
        u_neg_reg[1] <= sin_val[1].neg;
        u_neg_reg[2] <= sin_val[0].neg ^ sin_val[2].neg;
        for (int j = 0; j < 3; j++)
        begin
            pm_reg[j] <= pm_next[j];
            nm_reg[j] <= nm_next[j];
            s_neg_reg[j] <= u_neg_reg[j];
            if (meta_pipe[POS_OUT-1].oog)
            begin
                pos_reg[j] <= '0;
            end
            else if (s_neg_reg[j])
            begin
                pos_reg[j] <= -$signed({1'b0, pm_reg[j]});
            end
            else
            begin
                pos_reg[j] <= $signed({1'b0, pm_reg[j]});
            end
            if (meta_pipe[POS_OUT-1].oog || (radius_reg == '0))
            begin
                norm_reg[j] <= '0;
            end
            else if (s_neg_reg[j])
            begin
                norm_reg[j] <= $signed({1'b0, nm_reg[j]});
            end
            else
            begin
                norm_reg[j] <= -$signed({1'b0, nm_reg[j]});
            end
        end
        tex_u_reg <= meta_pipe[POS_OUT-1].oog ? '0 : tex_pipe[POS_OUT-1].u;
        tex_v_reg <= meta_pipe[POS_OUT-1].oog ? '0 : tex_pipe[POS_OUT-1].v;
        qv_reg <= meta_pipe[POS_OUT-1].qv;
        cur_reg <= meta_pipe[POS_OUT-1].qv ? meta_pipe[POS_OUT-1].cur : '0;
        nxt_reg <= meta_pipe[POS_OUT-1].qv ? meta_pipe[POS_OUT-1].nxt : '0;
        oog_reg <= meta_pipe[POS_OUT-1].oog;
    end

    assign done = vld_reg[POS_OUT];
    assign pos_x = pos_reg[0];
    assign pos_y = pos_reg[1];
    assign pos_z = pos_reg[2];
    assign norm_x = norm_reg[0];
    assign norm_y = norm_reg[1];
    assign norm_z = norm_reg[2];
    assign tex_u = tex_u_reg;
    assign tex_v = tex_v_reg;
    assign quad_valid = qv_reg;
    assign base_current = cur_reg;
    assign base_next = nxt_reg;
    assign out_of_grid = oog_reg;

    // Every field but the flag is zero
    assign oog_fields_zero = (pos_x == '0) && (pos_y == '0) && (pos_z == '0)
        && (norm_x == '0) && (norm_y == '0) && (norm_z == '0)
        && (tex_u == '0) && (tex_v == '0) && !quad_valid;

    // Assertions
    `SGVG_ASSERT_IMP(a_oog_zero, done && out_of_grid, oog_fields_zero)
    `SGVG_ASSERT_IMP(a_base_zero, done && !quad_valid, base_current == 0 && base_next == 0)
    `SGVG_ASSERT_IMP(a_norm_range, done, (norm_y <= 16'sd16384) && (norm_y >= -16'sd16384))
    `SGVG_ASSERT_NXT(a_oog_entry, accept && (ring_index > rings), oog0_reg)

endmodule

`default_nettype wire
